@@ design/rdf_pkg.sv @@
`timescale 1ns / 1ps

package rdf_pkg;

  localparam int DIGIT_W         = 6;
  localparam int CHAR_W          = 7;
  localparam int RADIX_W         = 6;
  localparam int MAX_DIGITS_DEF  = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [RADIX_W-1:0] radix_t;

  localparam radix_t RADIX_MIN   = 6'd2;
  localparam radix_t RADIX_MAX   = 6'd36;
  localparam radix_t RADIX_RESET = 6'd10;

  localparam char_t ASCII_ZERO = 7'd48;  // '0'
  localparam char_t ASCII_A    = 7'd65;  // 'A'
  localparam digit_t DEC_DIGITS = 6'd10;

  // 0-9 -> '0'-'9', 10-35 -> 'A'-'Z'
  function automatic char_t digit_to_ascii(input digit_t d);
    char_t c;
    if (d < DEC_DIGITS) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

@@ design/radix_digit_formatter_core.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         start / busy         in_number_value
// result    out        out_valid (strobe)   out_digit_char, out_last_digit
// config    in         cfg_we               cfg_wdata (radix, clamped to 2..36)
//
// A transaction is taken at a clock edge with start high and busy low.
// Each digit comes from a bit-serial restoring division by the radix, so
// a number with D digits (D <= MAX_DIGITS) keeps busy high through all of
// its divisions and while its digits are sent.
// Digits leave one per cycle, most significant first, each on out_valid
// for exactly one cycle; the receiver cannot stall the output.
// rst_n is synchronous, active low; it clears control state and sets the
// radix to 10. The digit stack needs no reset.
module radix_digit_formatter_core #(
  parameter int MAX_DIGITS  = rdf_pkg::MAX_DIGITS_DEF,
  parameter int VALUE_WIDTH = rdf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    start,
  output logic                    busy,
  input  logic [VALUE_WIDTH-1:0]  in_number_value,
  // result channel
  output logic                    out_valid,
  output rdf_pkg::char_t          out_digit_char,
  output logic                    out_last_digit,
  // configuration
  input  logic                    cfg_we,
  input  rdf_pkg::radix_t         cfg_wdata
);
  import rdf_pkg::*;

  localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
  localparam int CNT_W     = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VALUE_WIDTH - 1);
  localparam logic [CNT_W-1:0]     CNT_FULL = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0]     CNT_ONE  = CNT_W'(1);

  logic [1:0]             state_r, state_nxt;
  radix_t                 radix_r, radix_nxt;
  // quotient/dividend shift register: dividend bits leave at the top,
  // quotient bits enter at the bottom
  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  digit_t                 rem_r, rem_nxt;
  logic                   nz_r, nz_nxt;     // any quotient bit set so far
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;   // digits held in the stack
  digit_t                 stack_r [MAX_DIGITS];
  digit_t                 stack_nxt [MAX_DIGITS];
  logic                   out_valid_r, out_valid_nxt;
  char_t                  out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  // one restoring-division step
  logic [DIGIT_W:0]       rem_sh;
  logic                   q_bit;
  logic [DIGIT_W:0]       rem_sub;

  assign rem_sh  = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign q_bit   = (rem_sh >= {1'b0, radix_r});
  assign rem_sub = rem_sh - {1'b0, radix_r};

  always_comb begin
    state_nxt     = state_r;
    radix_nxt     = radix_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    nz_nxt        = nz_r;
    bit_cnt_nxt   = bit_cnt_r;
    cnt_nxt       = cnt_r;
    stack_nxt     = stack_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    // the user must write config only while idle (the block does not enforce it); clamp into the legal range
    if (cfg_we) begin
      if (cfg_wdata < RADIX_MIN) begin
        radix_nxt = RADIX_MIN;
      end else if (cfg_wdata > RADIX_MAX) begin
        radix_nxt = RADIX_MAX;
      end else begin
        radix_nxt = cfg_wdata;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          quo_nxt     = in_number_value;
          rem_nxt     = '0;
          nz_nxt      = 1'b0;
          bit_cnt_nxt = '0;
          cnt_nxt     = '0;
          state_nxt   = ST_DIV;
        end
      end

      ST_DIV: begin
        quo_nxt     = {quo_r[VALUE_WIDTH-2:0], q_bit};
        rem_nxt     = q_bit ? rem_sub[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
        nz_nxt      = nz_r | q_bit;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == LAST_BIT) begin
          // push the remainder; the oldest digit falls off a full stack
          stack_nxt[0] = rem_nxt;
          for (int i = 1; i < MAX_DIGITS; i++) begin
            stack_nxt[i] = stack_r[i-1];
          end
          if (cnt_r != CNT_FULL) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          rem_nxt     = '0;
          nz_nxt      = 1'b0;
          bit_cnt_nxt = '0;
          if (!(nz_r | q_bit)) begin
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = digit_to_ascii(stack_r[0]);
        out_last_nxt  = (cnt_r == CNT_ONE);
        for (int i = 0; i < MAX_DIGITS - 1; i++) begin
          stack_nxt[i] = stack_r[i+1];
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_ONE) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radix_r     <= RADIX_RESET;
      cnt_r       <= '0;
      bit_cnt_r   <= '0;
      nz_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radix_r     <= radix_nxt;
      cnt_r       <= cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      nz_r        <= nz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    stack_r    <= stack_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

endmodule

@@ design/rdf_checker.sv @@
`timescale 1ns / 1ps

module rdf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input rdf_pkg::char_t out_digit_char,
  input logic           out_last_digit
);
  import rdf_pkg::*;

  // accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  // only the final digit may come after busy drops
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_digit |-> !busy)
    else $error("busy still high with final digit");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_digit |-> busy)
    else $error("non-final digit shown while idle");

  // end of a transaction is marked by its final digit
  a_fall_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid && out_last_digit)
    else $error("busy dropped without final digit");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= 7'd48 && out_digit_char <= 7'd57) ||
                  (out_digit_char >= 7'd65 && out_digit_char <= 7'd90))
    else $error("digit character out of range");

endmodule

bind radix_digit_formatter_core rdf_checker u_rdf_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import rdf_pkg::*;

  localparam int VALUE_W     = VALUE_WIDTH_DEF;
  // Longest legal quiet stretch: the divisions of a 32-digit base-2 number
  // before its first digit, plus the longest sender gap. Several x.
  localparam int STALL_LIMIT = 12000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 27;

  // One expected digit transaction on the result channel.
  typedef struct packed {
    char_t ch;
    logic  last;
  } digit_exp_t;

  // Digit predictor plus the queue of digits still owed by the block.
  class radix_digit_checker;
    radix_t     radix;
    digit_exp_t pending[$];
    int         errors;

    function new();
      radix  = RADIX_RESET;
      errors = 0;
    endfunction

    // Mirror of the register write, with the block's 2..36 clamp.
    function void set_radix(input radix_t wdata);
      if (wdata < RADIX_MIN) begin
        radix = RADIX_MIN;
      end else if (wdata > RADIX_MAX) begin
        radix = RADIX_MAX;
      end else begin
        radix = wdata;
      end
    endfunction

    // Split the value into digits, MSD first; flag the final one.
    function void note_number(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] quot;
      digit_t             stack[$];
      digit_t             d;
      digit_exp_t         e;
      int                 i;
      quot = value;
      do begin
        d    = digit_t'(quot % radix);
        quot = quot / radix;
        stack.push_front(d);
      end while (quot != 0);
      for (i = 0; i < stack.size(); i++) begin
        d = stack[i];
        if (d < DEC_DIGITS) begin
          e.ch = ASCII_ZERO + char_t'(d);
        end else begin
          e.ch = ASCII_A + char_t'(d - DEC_DIGITS);
        end
        e.last = (i == stack.size() - 1);
        pending.push_back(e);
      end
    endfunction

    function void check_digit(input char_t ch, input logic last);
      digit_exp_t e;
      if (pending.size() == 0) begin
        $error("unexpected digit: digit_char %0d last_digit %0b", ch, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (ch !== e.ch) begin
        $error("digit_char: expected %0d, got %0d", e.ch, ch);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_digit: expected %0b, got %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk   = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [VALUE_W-1:0] in_number_value = '0;
  logic               out_valid;
  char_t              out_digit_char;
  logic               out_last_digit;
  logic               cfg_we    = 1'b0;
  radix_t             cfg_wdata = RADIX_RESET;

  radix_digit_checker digits = new();
  int                 stall_cycles = 0;

  radix_digit_formatter_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_number_value (in_number_value),
    .out_valid       (out_valid),
    .out_digit_char  (out_digit_char),
    .out_last_digit  (out_last_digit),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result monitor: the strobe cannot be stalled, so every cycle with
  // out_valid high is one digit transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      digits.check_digit(out_digit_char, out_last_digit);
    end
  end

  // Watchdog: any transaction on either channel resets the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Mostly back-to-back, some short gaps, a few long enough to span a
  // whole conversion.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(30, 1200);
  endfunction

  // Value mix aimed at digit-count boundaries of the current radix.
  function automatic logic [VALUE_W-1:0] pick_value();
    longint unsigned p;
    int              k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4: return $urandom_range(0, int'(digits.radix) * int'(digits.radix));
      5: return {VALUE_W{1'b1}} >> $urandom_range(0, VALUE_W - 1);
      6: return {{(VALUE_W-1){1'b0}}, 1'b1} << $urandom_range(0, VALUE_W - 1);
      7: begin
        // radix^k or radix^k - 1, k capped to what fits
        p = 1;
        k = $urandom_range(1, VALUE_W);
        while (k > 0 && p * digits.radix <= 64'hFFFF_FFFF) begin
          p = p * digits.radix;
          k--;
        end
        return ($urandom_range(0, 1) != 0) ? VALUE_W'(p) : VALUE_W'(p - 1);
      end
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  // Called at a posedge step. Start stays high into the next transaction
  // when there is no gap, so it is assigned only once per step.
  task automatic send_number(input logic [VALUE_W-1:0] value);
    int gap;
    start           <= 1'b1;
    in_number_value <= value;
    do @(posedge clk); while (busy);
    digits.note_number(value);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every owed digit is out and busy drops.
  task automatic wait_idle();
    start <= 1'b0;
    while (digits.pending.size() != 0 || busy) @(posedge clk);
    @(posedge clk);
  endtask

  // Only called while idle.
  task automatic write_radix(input radix_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    digits.set_radix(value);
  endtask

  initial begin
    int ph;
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset radix 10: zero, single digit edges, all ones, top bit, a power of ten.
    send_number(32'd0);
    send_number(32'd9);
    send_number(32'd10);
    send_number(32'hFFFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'd1_000_000_000);
    wait_idle();

    // Writes of 0 and 1 clamp to base 2; longest number is 32 digits.
    write_radix(6'd0);
    send_number(32'd1);
    send_number(32'hFFFF_FFFF);
    send_number(32'hAAAA_AAAA);
    wait_idle();
    write_radix(6'd1);
    send_number(32'h5555_5555);
    wait_idle();

    // Above-range writes clamp to 36; digits up to 'Z'.
    write_radix(6'd63);
    send_number(32'd35);
    send_number(32'd36);
    send_number(32'hFFFF_FFFF);
    wait_idle();
    write_radix(6'd37);
    send_number(32'd0);
    send_number(32'd1_679_615);  // ZZZZ
    wait_idle();

    write_radix(6'd16);
    send_number(32'hDEAD_BEEF);
    send_number(32'h0123_ABCD);
    wait_idle();
    write_radix(RADIX_MAX);
    send_number(32'd1_295);      // ZZ
    wait_idle();

    // Random phases, each with its own radix; first two at the extremes.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        write_radix(RADIX_MIN);
      end else if (ph == 1) begin
        write_radix(RADIX_MAX);
      end else begin
        write_radix(radix_t'($urandom_range(0, 63)));
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_number(pick_value());
        if ($urandom_range(0, 19) == 0) begin
          wait_idle();
        end
      end
      wait_idle();
    end

    // Drain and let the block settle before the verdict.
    wait_idle();
    repeat (64) @(posedge clk);
    if (digits.pending.size() != 0) begin
      $error("%0d digits never arrived", digits.pending.size());
      digits.errors++;
    end
    if (digits.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/rdf_pkg.sv
design/radix_digit_formatter_core.sv
design/rdf_checker.sv
tb/tb.sv
